/* hdl/adbd_pkg.sv */
package adbd_pkg;

  localparam int unsigned FILTER_COUNT = 5;
  localparam int unsigned COEF_W       = 8;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned INDEX_W      = 5;
  localparam int unsigned FLAG_W       = 3;
  localparam int unsigned POS_W        = 4;

  localparam logic [POS_W-1:0] POS_HEADER = 4'd0;
  localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA0  = 4'd2;

  localparam logic [3:0] FILTER_MAX = 4'd4;

  typedef struct packed {
    logic [3:0] shift;
    logic [3:0] filter;
  } blk_cfg_t;

  // Weight on the newer history sample, scaled by 64; zero for an unknown filter.
  function automatic logic signed [COEF_W-1:0] coef_newer(input logic [3:0] sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      4'd1:    c = 8'sd60;
      4'd2:    c = 8'sd115;
      4'd3:    c = 8'sd98;
      4'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  // Weight on the older history sample, scaled by 64.
  function automatic logic signed [COEF_W-1:0] coef_older(input logic [3:0] sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      4'd2:    c = -8'sd52;
      4'd3:    c = -8'sd55;
      4'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/adpcm_block_decoder.sv */
// Channel   Handshake            Payload
// in        in_valid/in_ready    data_byte[7:0], restart_voice
// out       out_valid/out_ready  sample[15:0], sample_index[4:0], last_of_byte,
//                                loop_flags[2:0], bad_filter
//
// A header or flag byte is taken and yields no result.
// A data byte is held while the shared filter produces one sample per cycle unless
// stalled (low nibble, then high nibble); the next byte is taken with the high nibble.
// Each sample feeds the next through the history registers.
// Reset clears block position, header fields, flags, history and valids.
// A stalled output register freezes the filter; the next byte waits in the source.
module adpcm_block_decoder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             data_byte,
  input  logic                                   restart_voice,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [adbd_pkg::SAMPLE_W-1:0]   sample,
  output logic [adbd_pkg::INDEX_W-1:0]           sample_index,
  output logic                                   last_of_byte,
  output logic [adbd_pkg::FLAG_W-1:0]            loop_flags,
  output logic                                   bad_filter
);

  logic [adbd_pkg::POS_W-1:0]          byte_pos;
  adbd_pkg::blk_cfg_t                  cfg;
  logic [adbd_pkg::FLAG_W-1:0]         flags;
  logic signed [adbd_pkg::SAMPLE_W-1:0] hist_newer;
  logic signed [adbd_pkg::SAMPLE_W-1:0] hist_older;
  logic                                busy;
  logic                                phase;
  logic [7:0]                          held_byte;
  logic [adbd_pkg::POS_W-1:0]          held_slot;

  logic [adbd_pkg::POS_W-1:0]          pos_eff;
  logic                                advance;
  logic                                done_byte;
  logic                                accept;
  logic                                load_data;
  logic [3:0]                          nibble;
  logic signed [adbd_pkg::SAMPLE_W-1:0] filt_sample;

  assign advance   = busy && (!out_valid || out_ready);
  assign done_byte = advance && phase;
  assign in_ready  = !busy || done_byte;
  assign accept    = in_valid && in_ready;
  assign pos_eff   = restart_voice ? adbd_pkg::POS_HEADER : byte_pos;
  assign load_data = (pos_eff != adbd_pkg::POS_HEADER) && (pos_eff != adbd_pkg::POS_FLAGS);
  assign nibble    = phase ? held_byte[7:4] : held_byte[3:0];

  adbd_filter u_filter (
    .nibble     (nibble),
    .cfg        (cfg),
    .hist_newer (hist_newer),
    .hist_older (hist_older),
    .sample     (filt_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= adbd_pkg::POS_HEADER;
      cfg        <= '0;
      flags      <= '0;
      hist_newer <= '0;
      hist_older <= '0;
      busy       <= 1'b0;
      phase      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // restart wins over the history update of a finishing byte
      if (accept && restart_voice) begin
        hist_newer <= '0;
        hist_older <= '0;
      end else if (advance) begin
        hist_older <= hist_newer;
        hist_newer <= filt_sample;
      end
      if (accept && load_data) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (advance) begin
        phase <= ~phase;
        if (phase) begin
          busy <= 1'b0;
        end
      end
      if (accept) begin
        if (pos_eff == adbd_pkg::POS_HEADER) begin
          cfg.shift  <= data_byte[3:0];
          cfg.filter <= data_byte[7:4];
          byte_pos   <= adbd_pkg::POS_FLAGS;
        end else if (pos_eff == adbd_pkg::POS_FLAGS) begin
          flags    <= data_byte[adbd_pkg::FLAG_W-1:0];
          byte_pos <= adbd_pkg::POS_DATA0;
        end else begin
          byte_pos <= pos_eff + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= data_byte;
      held_slot <= pos_eff - adbd_pkg::POS_DATA0;
    end
    if (advance) begin
      sample       <= filt_sample;
      sample_index <= {held_slot, phase};
      last_of_byte <= phase;
      loop_flags   <= flags;
      bad_filter   <= (cfg.filter > adbd_pkg::FILTER_MAX);
    end
  end

  a_data_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart_voice && byte_pos != adbd_pkg::POS_HEADER
     && byte_pos != adbd_pkg::POS_FLAGS) |=> (busy && !phase))
    else $error("data byte did not start a two-sample pass");

  a_second_sample: assert property (@(posedge clk) disable iff (rst)
    done_byte |=> (out_valid && last_of_byte && !busy || out_valid && last_of_byte && busy))
    else $error("high-nibble sample not presented");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample_index <= 5'd27 && sample_index[0] == last_of_byte))
    else $error("sample index out of block range");

  a_no_accept_midbyte: assert property (@(posedge clk) disable iff (rst)
    (busy && !phase) |-> !in_ready)
    else $error("input taken while low nibble pending");

endmodule

/* hdl/adbd_filter.sv */
module adbd_filter (
  input  logic [3:0]                              nibble,
  input  adbd_pkg::blk_cfg_t                      cfg,
  input  logic signed [adbd_pkg::SAMPLE_W-1:0]    hist_newer,
  input  logic signed [adbd_pkg::SAMPLE_W-1:0]    hist_older,
  output logic signed [adbd_pkg::SAMPLE_W-1:0]    sample
);

  localparam int unsigned PROD_W = adbd_pkg::SAMPLE_W + adbd_pkg::COEF_W;
  localparam int unsigned ACC_W  = adbd_pkg::SAMPLE_W + 4;

  logic signed [adbd_pkg::SAMPLE_W-1:0] raw;
  logic signed [adbd_pkg::SAMPLE_W-1:0] raw_sh;
  logic signed [adbd_pkg::COEF_W-1:0]   c0;
  logic signed [adbd_pkg::COEF_W-1:0]   c1;
  logic signed [PROD_W-1:0]             p0;
  logic signed [PROD_W-1:0]             p1;
  logic signed [PROD_W-1:0]             p0_sh;
  logic signed [PROD_W-1:0]             p1_sh;
  logic signed [ACC_W-1:0]              acc;

  always_comb begin
    raw    = {nibble, 12'd0};
    raw_sh = raw >>> cfg.shift;
    c0     = adbd_pkg::coef_newer(cfg.filter);
    c1     = adbd_pkg::coef_older(cfg.filter);
    p0     = hist_newer * c0;
    p1     = hist_older * c1;
    p0_sh  = p0 >>> 6;
    p1_sh  = p1 >>> 6;
    acc    = ACC_W'(raw_sh) + ACC_W'(p0_sh) + ACC_W'(p1_sh);
    // clamp to the 16-bit sample range
    if (acc > ACC_W'(32767)) begin
      sample = 16'sh7fff;
    end else if (acc < -ACC_W'(32768)) begin
      sample = -16'sh8000;
    end else begin
      sample = acc[adbd_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

/* verif/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1550;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_LIMIT     = 5000;

  typedef struct {
    logic signed [adbd_pkg::SAMPLE_W-1:0] sample;
    logic [adbd_pkg::INDEX_W-1:0]         sample_index;
    logic                                 last_of_byte;
    logic [adbd_pkg::FLAG_W-1:0]          loop_flags;
    logic                                 bad_filter;
  } decoded_sample_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_SPARSE} stall_mode_t;

  class sample_scoreboard;
    decoded_sample_t              expected_samples[$];
    int                           errors;
    logic [adbd_pkg::POS_W-1:0]   position;
    logic [3:0]                   shift;
    logic [3:0]                   filter;
    logic [adbd_pkg::FLAG_W-1:0]  flags;
    int                           hist_newer;
    int                           hist_older;
    int                           weight_newer[adbd_pkg::FILTER_COUNT];
    int                           weight_older[adbd_pkg::FILTER_COUNT];

    function new();
      weight_newer = '{0, 60, 115, 98, 122};
      weight_older = '{0, 0, -52, -55, -60};
      errors       = 0;
      position     = adbd_pkg::POS_HEADER;
      shift        = '0;
      filter       = '0;
      flags        = '0;
      hist_newer   = 0;
      hist_older   = 0;
    endfunction

    // Advance the decoder state by one accepted byte and queue the samples it yields.
    function void note_request(logic [7:0] b, logic restart);
      decoded_sample_t s;
      logic [3:0]      nib;
      int              base;
      int              acc;
      int              w_new;
      int              w_old;
      if (restart) begin
        hist_newer = 0;
        hist_older = 0;
        position   = adbd_pkg::POS_HEADER;
      end
      if (position == adbd_pkg::POS_HEADER) begin
        shift    = b[3:0];
        filter   = b[7:4];
        position = adbd_pkg::POS_FLAGS;
      end else if (position == adbd_pkg::POS_FLAGS) begin
        flags    = b[adbd_pkg::FLAG_W-1:0];
        position = adbd_pkg::POS_DATA0;
      end else begin
        w_new = (filter <= adbd_pkg::FILTER_MAX) ? weight_newer[filter] : 0;
        w_old = (filter <= adbd_pkg::FILTER_MAX) ? weight_older[filter] : 0;
        base  = (int'(position) - int'(adbd_pkg::POS_DATA0)) * 2;
        for (int k = 0; k < 2; k++) begin
          nib = (k == 0) ? b[3:0] : b[7:4];
          acc = {{16{nib[3]}}, nib, 12'h000};
          acc = (acc >>> shift) + ((hist_newer * w_new) >>> 6)
              + ((hist_older * w_old) >>> 6);
          if (acc > 32767) acc = 32767;
          if (acc < -32768) acc = -32768;
          hist_older     = hist_newer;
          hist_newer     = acc;
          s.sample       = acc[adbd_pkg::SAMPLE_W-1:0];
          s.sample_index = adbd_pkg::INDEX_W'(base + k);
          s.last_of_byte = (k == 1);
          s.loop_flags   = flags;
          s.bad_filter   = (filter > adbd_pkg::FILTER_MAX);
          expected_samples.push_back(s);
        end
        position = position + 1'b1;
      end
    endfunction

    function void check_result(decoded_sample_t got);
      decoded_sample_t want;
      if (expected_samples.size() == 0) begin
        $error("sample %0d (index %0d) arrived with no request outstanding",
               got.sample, got.sample_index);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample) begin
        $error("sample: expected %0d, got %0d", want.sample, got.sample);
        errors++;
      end
      if (got.sample_index !== want.sample_index) begin
        $error("sample_index: expected %0d, got %0d", want.sample_index, got.sample_index);
        errors++;
      end
      if (got.last_of_byte !== want.last_of_byte) begin
        $error("last_of_byte: expected %0d, got %0d", want.last_of_byte, got.last_of_byte);
        errors++;
      end
      if (got.loop_flags !== want.loop_flags) begin
        $error("loop_flags: expected %0d, got %0d", want.loop_flags, got.loop_flags);
        errors++;
      end
      if (got.bad_filter !== want.bad_filter) begin
        $error("bad_filter: expected %0d, got %0d", want.bad_filter, got.bad_filter);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [7:0]                           data_byte;
  logic                                 restart_voice;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [adbd_pkg::SAMPLE_W-1:0] sample;
  logic [adbd_pkg::INDEX_W-1:0]         sample_index;
  logic                                 last_of_byte;
  logic [adbd_pkg::FLAG_W-1:0]          loop_flags;
  logic                                 bad_filter;

  sample_scoreboard sb;
  int               burst_left;
  int               sent;
  bit               random_started;

  adpcm_block_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .restart_voice (restart_voice),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample),
    .sample_index  (sample_index),
    .last_of_byte  (last_of_byte),
    .loop_flags    (loop_flags),
    .bad_filter    (bad_filter)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_request(data_byte, restart_voice);
    end
  end

  always @(posedge clk) begin
    decoded_sample_t got;
    if (!rst && out_valid && out_ready) begin
      got.sample       = sample;
      got.sample_index = sample_index;
      got.last_of_byte = last_of_byte;
      got.loop_flags   = loop_flags;
      got.bad_filter   = bad_filter;
      sb.check_result(got);
    end
  end

  // Offer one request, hold it until taken, then sometimes idle between bursts.
  task automatic send_request(input logic [7:0] b, input logic restart);
    int gap;
    in_valid      <= 1'b1;
    data_byte     <= b;
    restart_voice <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          seg_len;
    bit          hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (random_started && !hold_done) begin
        // Hold off long enough for the decoder to fill and push back on its input.
        repeat (LONG_HOLD) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end
      mode    = stall_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 80);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          READY_MOSTLY: out_ready <= (i % 4 != 3);
          default:      out_ready <= (i % 7 < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    bit         aligned;
    int         block_len;
    int         waited;
    logic [3:0] hdr_shift;
    logic [3:0] hdr_filter;
    logic [7:0] b;
    logic       restart;
    sb             = new();
    sent           = 0;
    burst_left     = 4;
    random_started = 1'b0;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    data_byte     <= '0;
    restart_voice <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Strongest filter, no shift: drive into both saturation limits.
    send_request(8'h40, 1'b1);
    send_request(8'hfd, 1'b0);   // high flag bits are dropped
    send_request(8'h77, 1'b0);
    send_request(8'h77, 1'b0);
    send_request(8'h77, 1'b0);
    send_request(8'h88, 1'b0);
    send_request(8'h88, 1'b0);
    send_request(8'h88, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hff, 1'b0);
    // Restart mid-block onto an unknown filter with a large shift.
    send_request(8'hfd, 1'b1);
    send_request(8'h07, 1'b0);
    send_request(8'h88, 1'b0);
    send_request(8'h7f, 1'b0);
    // First filter above four, largest shift; flags keep their old value until rewritten.
    send_request(8'h5f, 1'b1);
    send_request(8'h00, 1'b0);
    send_request(8'hf0, 1'b0);
    send_request(8'h0f, 1'b0);
    send_request(8'h1c, 1'b1);
    send_request(8'h02, 1'b0);
    send_request(8'h81, 1'b0);
    send_request(8'h18, 1'b0);

    random_started = 1'b1;
    aligned        = 1'b0;
    sent           = 0;
    while (sent < RANDOM_REQUESTS) begin
      hdr_shift  = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(13, 15))
                                                : 4'($urandom_range(0, 12));
      hdr_filter = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(5, 15))
                                                : 4'($urandom_range(0, 4));
      restart    = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
      aligned    = 1'b1;
      block_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 16;
      send_request({hdr_filter, hdr_shift}, restart);
      for (int i = 1; i < block_len; i++) begin
        b = 8'($urandom);
        if (i >= 2 && $urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       b = 8'h77;
            1:       b = 8'h88;
            2:       b = 8'h00;
            default: b = 8'hff;
          endcase
        end
        // Occasionally break the block with a stray restart.
        restart = ($urandom_range(0, 39) == 0);
        if (restart) aligned = 1'b0;
        send_request(b, restart);
      end
      if (block_len < 16) aligned = 1'b0;
    end
    in_valid <= 1'b0;
    // let the last accepted request reach the scoreboard first
    @(posedge clk);

    waited = 0;
    while (sb.expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", sb.expected_samples.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
